// ----- hdl/gamepad_report_change_events_core_macros.svh -----
// Assertion macros for the gamepad report change event core.
// Included by the RTL files that carry concurrent checks; needs nothing else.
`ifndef GAMEPAD_REPORT_CHANGE_EVENTS_CORE_MACROS_SVH
`define GAMEPAD_REPORT_CHANGE_EVENTS_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GPCE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GPCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/gpce_pkg.sv -----
// Shared types, constants and helper functions for the gamepad report change event core.
// Depends on nothing; imported by the core top level.
`default_nettype none

package gpce_pkg;

  // Slot and player numbering
  localparam int PADS     = 4;
  localparam int PAD_W    = 2;
  localparam int PLAYER_W = (PADS > 4) ? $clog2(PADS) : 2;

  // Event list layout: buttons first, then axes
  localparam int NUM_BUTTONS = 14;
  localparam int NUM_AXES    = 6;
  localparam int NUM_EVENTS  = NUM_BUTTONS + NUM_AXES;
  localparam int EVT_IDX_W   = $clog2(NUM_EVENTS);
  localparam int BTN_IDX_W   = $clog2(NUM_BUTTONS);
  localparam int AXIS_IDX_W  = $clog2(NUM_AXES);
  localparam int CTRL_W      = 4;
  localparam int AXIS_W      = 16;

  // Event kinds
  localparam logic [1:0] KIND_PRESS   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_AXIS    = 2'd2;

  // Stick minimum and its reported replacement
  localparam logic [AXIS_W-1:0] STICK_MIN     = 16'h8000;
  localparam logic [AXIS_W-1:0] STICK_MIN_OUT = 16'h8001;

  // Stored report of one slot
  typedef struct packed {
    logic [31:0]       packet;
    logic [15:0]       buttons;
    logic [7:0]        left_trigger;
    logic [7:0]        right_trigger;
    logic [AXIS_W-1:0] left_x;
    logic [AXIS_W-1:0] left_y;
    logic [AXIS_W-1:0] right_x;
    logic [AXIS_W-1:0] right_y;
  } report_t;

  localparam int REPORT_W = $bits(report_t);

  typedef logic [NUM_AXES-1:0][AXIS_W-1:0] axes_t;

  // Report bit tested for each button index
  localparam logic [15:0] BUTTON_MASK [NUM_BUTTONS] = '{
    16'h0010, 16'h0020, 16'h0001, 16'h0002, 16'h0004, 16'h0008, 16'h0040,
    16'h0080, 16'h0100, 16'h0200, 16'h8000, 16'h1000, 16'h4000, 16'h2000
  };

  // Gather the mapped button bits in event order
  function automatic logic [NUM_BUTTONS-1:0] map_buttons(input logic [15:0] b);
    logic [NUM_BUTTONS-1:0] m;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      m[i] = |(b & BUTTON_MASK[i]);
    end
    return m;
  endfunction

  // (v*257)>>1 is the byte repeated and shifted right by one
  function automatic logic [AXIS_W-1:0] scale_trigger(input logic [7:0] v);
    return {1'b0, v, v[7:1]};
  endfunction

  // Axis values of a report in event order
  function automatic axes_t axes_of(input report_t r);
    axes_t a;
    a[0] = scale_trigger(r.left_trigger);
    a[1] = scale_trigger(r.right_trigger);
    a[2] = r.left_x;
    a[3] = r.left_y;
    a[4] = r.right_x;
    a[5] = r.right_y;
    return a;
  endfunction

  // Report the stick minimum one step higher
  function automatic logic [AXIS_W-1:0] clamp_axis(input logic [AXIS_W-1:0] v);
    return (v == STICK_MIN) ? STICK_MIN_OUT : v;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/gpce_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the per-slot report store of the event core.
`default_nettype none

module gpce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                                      clk,
  input  wire logic                                      wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                          wr_data,
  input  wire logic                                      rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/gamepad_report_change_events_core.sv -----
// Gamepad report change event core: top level.
// Depends on gpce_pkg, gpce_ram and the core assertion macro header.
//
// Usage:
//   Report channel (report_valid / report_stall): one polled report per
//   transaction, carrying slot, connected flag, packet number, buttons,
//   triggers and stick axes.
//   Event channel (event_valid / event_stall): zero to 20 events per report,
//   buttons first, then axes; the final event of a report has last set.
//   A report that changes nothing produces no transaction at all.
// Path: a report is taken into the read stage, compared against the store
//   read, loaded into the event stage and sent on through the output register.
// Throughput: one event per cycle while event_stall is low. The next report
//   is read from the store while the current one is still emitting.
//   The per-slot store is a RAM with one write and one registered read port;
//   a report that follows a write to its own slot takes the written data.
// Reset: all slots unassigned, all players free, every stored report reads
//   as zero; no clearing pass is needed.
// Stall: event_stall holds the output register, the event stage waits, and
//   report_stall rises once the read stage holds a report it cannot pass on.
`default_nettype none

module gamepad_report_change_events_core
  import gpce_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // Report channel
  input  wire logic                report_valid,
  output logic                     report_stall,
  input  wire logic [PAD_W-1:0]    pad,
  input  wire logic                connected,
  input  wire logic [31:0]         packet_number,
  input  wire logic [15:0]         buttons,
  input  wire logic [7:0]          left_trigger,
  input  wire logic [7:0]          right_trigger,
  input  wire logic signed [15:0]  left_x,
  input  wire logic signed [15:0]  left_y,
  input  wire logic signed [15:0]  right_x,
  input  wire logic signed [15:0]  right_y,
  // Event channel
  output logic                     event_valid,
  input  wire logic                event_stall,
  output logic [1:0]               event_kind,
  output logic [1:0]               player,
  output logic [CTRL_W-1:0]        control,
  output logic signed [15:0]       axis_value,
  output logic                     last
);

`include "gamepad_report_change_events_core_macros.svh"

  // Read stage
  logic             s1_valid;
  logic [PAD_W-1:0] s1_pad;
  logic             s1_conn;
  report_t          s1_rpt;
  logic             s1_fwd;
  report_t          s1_fwd_rpt;

  // Per-slot player state
  logic [PADS-1:0]     has_player;
  logic [PADS-1:0]     in_use;
  logic [PLAYER_W-1:0] player_of [PADS];
  logic [PADS-1:0]     rpt_valid;

  // Event stage
  logic [NUM_EVENTS-1:0]  pending;
  logic [NUM_EVENTS-1:0]  pending_next;
  logic [PLAYER_W-1:0]    s2_player;
  logic [NUM_BUTTONS-1:0] s2_press;
  axes_t                  s2_axis;

  // Report store
  logic                wr_en;
  logic [REPORT_W-1:0] rd_data;

  logic                  accept;
  logic                  s1_go;
  logic                  s2_free;
  logic                  emit;
  logic                  only_one;
  logic [NUM_EVENTS-1:0] lowbit;
  logic [EVT_IDX_W-1:0]  sel;
  logic [AXIS_IDX_W-1:0] axis_idx;

  logic                  in_range;
  report_t               prev;
  report_t               new_rpt;
  logic [PLAYER_W-1:0]   free_player;
  logic [PLAYER_W-1:0]   cur_player;
  logic                  is_new;
  logic                  take;
  axes_t                 prev_axes;
  axes_t                 new_axes;
  logic [NUM_EVENTS-1:0] pend_new;
  axes_t                 out_axes;

  gpce_ram #(
    .WIDTH (REPORT_W),
    .DEPTH (PADS)
  ) u_rpt_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_pad),
    .wr_data (new_rpt),
    .rd_en   (accept),
    .rd_addr (pad),
    .rd_data (rd_data)
  );

  // Handshake: event stage frees up as its last event leaves
  always_comb begin
    lowbit       = pending & (~pending + 1'b1);
    only_one     = (pending == lowbit);
    emit         = (pending != '0) && (!event_valid || !event_stall);
    s2_free      = (pending == '0) || (emit && only_one);
    s1_go        = s1_valid && s2_free;
    report_stall = s1_valid && !s2_free;
    accept       = report_valid && !report_stall;
  end

  // Compare the stored report with the incoming one
  always_comb begin
    in_range = (int'(s1_pad) < PADS);
    if (s1_fwd) begin
      prev = s1_fwd_rpt;
    end else if (rpt_valid[s1_pad]) begin
      prev = report_t'(rd_data);
    end else begin
      prev = '0;
    end
    new_rpt = s1_conn ? s1_rpt : '0;

    free_player = '0;
    for (int p = PADS - 1; p >= 0; p--) begin
      if (!in_use[p]) begin
        free_player = PLAYER_W'(p);
      end
    end
    cur_player = has_player[s1_pad] ? player_of[s1_pad] : free_player;
    is_new     = !has_player[s1_pad] || (s1_rpt.packet != prev.packet);
    take       = in_range && (s1_conn ? is_new : has_player[s1_pad]);

    prev_axes = axes_of(prev);
    new_axes  = axes_of(new_rpt);
    pend_new[NUM_BUTTONS-1:0] = map_buttons(prev.buttons ^ new_rpt.buttons);
    for (int a = 0; a < NUM_AXES; a++) begin
      pend_new[NUM_BUTTONS + a] = (prev_axes[a] != new_axes[a]);
      out_axes[a]               = clamp_axis(new_axes[a]);
    end
    wr_en = s1_go && take;
  end

  // Read stage register; forward a same-slot write made at the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pad             <= pad;
      s1_conn            <= connected;
      s1_rpt.packet      <= packet_number;
      s1_rpt.buttons     <= buttons;
      s1_rpt.left_trigger  <= left_trigger;
      s1_rpt.right_trigger <= right_trigger;
      s1_rpt.left_x      <= left_x;
      s1_rpt.left_y      <= left_y;
      s1_rpt.right_x     <= right_x;
      s1_rpt.right_y     <= right_y;
      s1_fwd             <= wr_en && (s1_pad == pad);
      s1_fwd_rpt         <= new_rpt;
    end
  end

  // Player assignment and release, store valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      has_player <= '0;
      in_use     <= '0;
      rpt_valid  <= '0;
      for (int i = 0; i < PADS; i++) begin
        player_of[i] <= '0;
      end
    end else if (s1_go && in_range) begin
      if (s1_conn && !has_player[s1_pad]) begin
        has_player[s1_pad]  <= 1'b1;
        player_of[s1_pad]   <= free_player;
        in_use[free_player] <= 1'b1;
      end else if (!s1_conn && has_player[s1_pad]) begin
        has_player[s1_pad]        <= 1'b0;
        player_of[s1_pad]         <= '0;
        in_use[player_of[s1_pad]] <= 1'b0;
      end
      if (take) begin
        rpt_valid[s1_pad] <= 1'b1;
      end
    end
  end

  // Event stage: load a new change set or drop the event just sent
  always_comb begin
    if (s1_go) begin
      pending_next = take ? pend_new : '0;
    end else if (emit) begin
      pending_next = pending & ~lowbit;
    end else begin
      pending_next = pending;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_player <= cur_player;
      s2_press  <= map_buttons(new_rpt.buttons);
      s2_axis   <= out_axes;
    end
  end

  // Encode the lowest pending event
  always_comb begin
    sel = '0;
    for (int i = 0; i < NUM_EVENTS; i++) begin
      if (lowbit[i]) begin
        sel = sel | EVT_IDX_W'(i);
      end
    end
    axis_idx = AXIS_IDX_W'(sel - EVT_IDX_W'(NUM_BUTTONS));
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (emit) begin
      event_valid <= 1'b1;
    end else if (!event_stall) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      player <= s2_player[1:0];
      last   <= only_one;
      if (int'(sel) < NUM_BUTTONS) begin
        event_kind <= s2_press[sel[BTN_IDX_W-1:0]] ? KIND_PRESS : KIND_RELEASE;
        control    <= CTRL_W'(sel);
        axis_value <= '0;
      end else begin
        event_kind <= KIND_AXIS;
        control    <= CTRL_W'(axis_idx);
        axis_value <= s2_axis[axis_idx];
      end
    end
  end

  // Assigned slots and players in use always match in number
  `GPCE_ASSERT_SAME(a_player_count, clk, rst, 1'b1,
    $countones(has_player) == $countones(in_use), "player count mismatch")
  // A report never enters the event stage over unsent events
  `GPCE_ASSERT_SAME(a_no_overrun, clk, rst, (pending != '0) && !(emit && only_one),
    !s1_go, "event stage overrun")
  // An emitted event lands in the output register with its last flag
  `GPCE_ASSERT_NEXT(a_emit_last, clk, rst, emit,
    event_valid && (last == $past(only_one)), "event lost or last flag wrong")

endmodule

`default_nettype wire
